### hdl/fixed_radius_neighbour_search_unit_defines.svh
// Assertion macros for the neighbour search unit.
`ifndef FIXED_RADIUS_NEIGHBOUR_SEARCH_UNIT_DEFINES_SVH
`define FIXED_RADIUS_NEIGHBOUR_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FRNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/frns_pkg.sv
`default_nettype none

package frns_pkg;

    localparam int DEF_MAX_PARTICLES = 1024;
    localparam int DEF_DIMENSIONS    = 3;

    localparam int SLOT_W     = 10;
    localparam int POS_W      = 32;
    localparam int RADIUS_W   = 31;
    localparam int RSQ_W      = 62;
    localparam int SQ_W       = 64;
    localparam int SUM_W      = 66;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 6;
    localparam int PCOUNT_W   = 11;
    localparam int LIMIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd0;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_LIMIT = 2'd1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_DONE     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic               load_we;
        logic               query_start;
        logic               issue;
        logic               flush;
        logic               out_load;
        status_t            out_status;
        logic [COUNT_W-1:0] out_count;
        logic               out_last;
    } frns_cmd_t;

    typedef struct packed {
        logic adv;
        logic hit;
        logic busy;
    } frns_status_t;

endpackage

`default_nettype wire

### hdl/frns_if.sv
`default_nettype none

interface frns_item_if import frns_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [SLOT_W-1:0]          slot;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [POS_W-1:0]    pos_z;
    logic                       alive;
    logic [RADIUS_W-1:0]        search_radius;

    modport source (output valid, opcode, slot, pos_x, pos_y, pos_z, alive, search_radius,
                    input ready);
    modport sink (input valid, opcode, slot, pos_x, pos_y, pos_z, alive, search_radius,
                  output ready);
endinterface

interface frns_result_if import frns_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] neighbour_index;
    logic [1:0]         status;
    logic [COUNT_W-1:0] found_count;
    logic               is_last;

    modport source (output valid, neighbour_index, status, found_count, is_last,
                    input ready);
    modport sink (input valid, neighbour_index, status, found_count, is_last,
                  output ready);
endinterface

interface frns_cfg_if import frns_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/frns_datapath.sv
`default_nettype none

module frns_datapath import frns_pkg::*; #(
    parameter int  MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int  DIMENSIONS    = DEF_DIMENSIONS,
    localparam int AW            = $clog2(MAX_PARTICLES)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [SLOT_W-1:0]       slot,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic                    alive,
    input  logic [RADIUS_W-1:0]     search_radius,
    input  frns_cmd_t               cmd,
    input  logic [AW-1:0]           scan_addr,
    output frns_status_t            st,
    frns_result_if.source           result
);

    localparam bit USE_Y = (DIMENSIONS >= 2);
    localparam bit USE_Z = (DIMENSIONS >= 3);

    // particle store, one read port for the scan
    logic [POS_W-1:0] mem_x [MAX_PARTICLES];
    logic [POS_W-1:0] mem_y [MAX_PARTICLES];
    logic [POS_W-1:0] mem_z [MAX_PARTICLES];
    logic             mem_alive [MAX_PARTICLES];

    logic [31:0]      slot_wide;
    logic             slot_ok;
    logic [AW-1:0]    wr_addr;
    logic             adv;

    logic [POS_W-1:0]    center_reg [3];
    logic [RADIUS_W-1:0] radius_reg;
    logic [RSQ_W-1:0]    rsq_reg;

    // stage 1: store read
    logic             v1_reg;
    logic [AW-1:0]    idx1_reg;
    logic [POS_W-1:0] rd_reg [3];
    logic             alive1_reg;
    // stage 2: absolute differences
    logic             v2_reg;
    logic [AW-1:0]    idx2_reg;
    logic             alive2_reg;
    logic [31:0]      mag_reg [3];
    logic [31:0]      mag_next [3];
    logic [32:0]      diff [3];
    logic [32:0]      absd [3];
    // stage 3: squares
    logic             v3_reg;
    logic [AW-1:0]    idx3_reg;
    logic             alive3_reg;
    logic [SQ_W-1:0]  sq_reg [3];
    // stage 4: compare
    logic             v4_reg;
    logic [AW-1:0]    idx4_reg;
    logic             hit4_reg;
    logic [SUM_W-1:0] sum_next;
    logic             hit4_next;

    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [INDEX_W-1:0] out_index_next;
    logic [1:0]         out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;
    logic [31:0]        idx4_wide;

    assign slot_wide = 32'(slot);
    assign slot_ok   = slot_wide < 32'(MAX_PARTICLES);
    assign wr_addr   = slot_wide[AW-1:0];

    // the whole scan pipe moves only when the output word can be refilled
    assign adv = !out_valid_reg || result.ready;

    assign st.adv  = adv;
    assign st.hit  = v4_reg && hit4_reg;
    assign st.busy = v1_reg || v2_reg || v3_reg || v4_reg;

    always_ff @(posedge clk) begin
        if (cmd.load_we && slot_ok) begin
            mem_x[wr_addr]     <= pos_x;
            mem_y[wr_addr]     <= pos_y;
            mem_z[wr_addr]     <= pos_z;
            mem_alive[wr_addr] <= alive;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            rd_reg[0]  <= mem_x[scan_addr];
            rd_reg[1]  <= mem_y[scan_addr];
            rd_reg[2]  <= mem_z[scan_addr];
            alive1_reg <= mem_alive[scan_addr];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k]     = {rd_reg[k][POS_W-1], rd_reg[k]}
                        - {center_reg[k][POS_W-1], center_reg[k]};
            absd[k]     = diff[k][32] ? (33'd0 - diff[k]) : diff[k];
            mag_next[k] = absd[k][31:0];
        end
        sum_next = SUM_W'(sq_reg[0])
                 + (USE_Y ? SUM_W'(sq_reg[1]) : '0)
                 + (USE_Z ? SUM_W'(sq_reg[2]) : '0);
        hit4_next = alive3_reg && (sum_next <= SUM_W'(rsq_reg));
        idx4_wide = 32'(idx4_reg);
        out_index_next = (cmd.out_status == ST_DONE) ? '0 : idx4_wide[INDEX_W-1:0];
    end

    always_ff @(posedge clk) begin
        if (cmd.query_start) begin
            center_reg[0] <= pos_x;
            center_reg[1] <= pos_y;
            center_reg[2] <= pos_z;
            radius_reg    <= search_radius;
        end
        rsq_reg <= radius_reg * radius_reg;
        if (adv) begin
            idx1_reg   <= scan_addr;
            idx2_reg   <= idx1_reg;
            alive2_reg <= alive1_reg;
            idx3_reg   <= idx2_reg;
            alive3_reg <= alive2_reg;
            idx4_reg   <= idx3_reg;
            hit4_reg   <= hit4_next;
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= mag_next[k];
                sq_reg[k]  <= mag_reg[k] * mag_reg[k];
            end
        end
        if (cmd.out_load) begin
            out_index_reg  <= out_index_next;
            out_status_reg <= cmd.out_status;
            out_count_reg  <= cmd.out_count;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.flush) begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
                v4_reg <= 1'b0;
            end else if (adv) begin
                v1_reg <= cmd.issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.neighbour_index = out_index_reg;
    assign result.status          = out_status_reg;
    assign result.found_count     = out_count_reg;
    assign result.is_last         = out_last_reg;

endmodule

`default_nettype wire

### hdl/frns_ctrl.sv
`default_nettype none

module frns_ctrl import frns_pkg::*; #(
    parameter int  MAX_PARTICLES = DEF_MAX_PARTICLES,
    localparam int AW            = $clog2(MAX_PARTICLES)
) (
    input  logic          clk,
    input  logic          rst_n,
    frns_item_if.sink     item,
    frns_cfg_if.sink      cfg,
    input  frns_status_t  st,
    output frns_cmd_t     cmd,
    output logic [AW-1:0] scan_addr
);

    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int WIDE_W = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [CNT_W-1:0]     neff_reg, neff_next;
    logic [COUNT_W-1:0]   found_reg, found_next;
    logic [PCOUNT_W-1:0]  pcount_reg, pcount_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [WIDE_W-1:0]    pcount_wide;
    logic [CNT_W-1:0]     addr_inc;
    logic                 item_take;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign scan_addr  = addr_reg;

    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        neff_next   = neff_reg;
        found_next  = found_reg;
        pcount_next = pcount_reg;
        limit_next  = limit_reg;
        pcount_wide = WIDE_W'(pcount_reg);
        addr_inc    = CNT_W'(addr_reg) + CNT_W'(1);
        item_take   = item.valid && item.ready;
        cmd         = '0;
        cmd.out_status = ST_FOUND;

        if (cfg.valid) begin
            case (cfg.index)
                CFG_PARTICLE_COUNT:  pcount_next = cfg.data[PCOUNT_W-1:0];
                CFG_NEIGHBOUR_LIMIT: limit_next  = cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (item_take) begin
                    if (item.opcode == OP_QUERY) begin
                        cmd.query_start = 1'b1;
                        found_next      = '0;
                        addr_next       = '0;
                        if (pcount_wide > WIDE_W'(MAX_PARTICLES)) begin
                            neff_next = CNT_W'(MAX_PARTICLES);
                        end else begin
                            neff_next = CNT_W'(pcount_reg);
                        end
                        state_next = (pcount_reg == '0) ? S_DRAIN : S_SCAN;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (st.adv) begin
                    cmd.issue = 1'b1;
                    addr_next = addr_reg + AW'(1);
                    if (addr_inc == neff_reg) begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // done word once the last slot has left the pipe
                if (st.adv && !st.busy) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DONE;
                    cmd.out_count  = found_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (st.adv && st.hit) begin
            cmd.out_load = 1'b1;
            if (found_reg >= limit_reg) begin
                cmd.out_status = ST_OVERFLOW;
                cmd.out_count  = found_reg;
                cmd.out_last   = 1'b1;
                cmd.flush      = 1'b1;
                state_next     = S_IDLE;
            end else begin
                cmd.out_status = ST_FOUND;
                cmd.out_count  = found_reg + COUNT_W'(1);
                found_next     = found_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            addr_reg   <= '0;
            neff_reg   <= '0;
            found_reg  <= '0;
            pcount_reg <= PCOUNT_RESET;
            limit_reg  <= LIMIT_RESET;
        end else begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            neff_reg   <= neff_next;
            found_reg  <= found_next;
            pcount_reg <= pcount_next;
            limit_reg  <= limit_next;
        end
    end

endmodule

`default_nettype wire

### hdl/fixed_radius_neighbour_search_unit.sv
// Fixed-radius neighbour search over a store of particle positions.
// item channel: a load word (opcode 0) writes one slot of the store; a query
// word (opcode 1) scans slots 0 .. min(particle_count, MAX_PARTICLES)-1 and
// returns one word per live particle inside the radius,
// in slot order, then a done word with is_last set. If a match arrives once
// neighbour_limit words were sent, an overflow word with is_last ends it.
// cfg channel: always ready; index 0 particle_count, index 1 neighbour_limit.
// Write it only while no query is running.
// The scan reads one slot per cycle from the single read port of the store,
// unless the result channel stalls; each slot passes the store read,
// difference, square and compare stages. item ready stays low until the
// last word of the query is in the output register.
// A stalled result channel freezes the scan pipe; nothing is dropped.
// Reset clears control and sets particle_count 0, neighbour_limit 63; the
// store is not cleared and must be loaded before it is scanned.
`default_nettype none

module fixed_radius_neighbour_search_unit import frns_pkg::*; #(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int DIMENSIONS    = DEF_DIMENSIONS
) (
    input  logic          clk,
    input  logic          rst_n,
    frns_item_if.sink     item,
    frns_cfg_if.sink      cfg,
    frns_result_if.source result
);

    localparam int AW = $clog2(MAX_PARTICLES);

    frns_cmd_t     cmd;
    frns_status_t  st;
    logic [AW-1:0] scan_addr;

    frns_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .st        (st),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    frns_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .DIMENSIONS    (DIMENSIONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .slot          (item.slot),
        .pos_x         (item.pos_x),
        .pos_y         (item.pos_y),
        .pos_z         (item.pos_z),
        .alive         (item.alive),
        .search_radius (item.search_radius),
        .cmd           (cmd),
        .scan_addr     (scan_addr),
        .st            (st),
        .result        (result)
    );

endmodule

`default_nettype wire

### hdl/frns_checker.sv
`default_nettype none
`include "fixed_radius_neighbour_search_unit_defines.svh"

module frns_checker import frns_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               item_opcode,
    input logic               result_valid,
    input logic               result_ready,
    input logic [INDEX_W-1:0] result_index,
    input logic [1:0]         result_status,
    input logic [COUNT_W-1:0] result_count,
    input logic               result_last
);

    `FRNS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result word dropped while stalled")
    `FRNS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_index) && $stable(result_status) && $stable(result_count) && $stable(result_last), "result payload changed while stalled")
    `FRNS_ASSERT_NOW(a_last_matches_status, result_valid, result_last == (result_status != ST_FOUND), "is_last does not match status")
    `FRNS_ASSERT_NOW(a_done_index_zero, result_valid && result_status == ST_DONE, result_index == '0, "done word with nonzero index")
    `FRNS_ASSERT_NEXT(a_query_blocks_items, item_valid && item_ready && item_opcode == OP_QUERY, !item_ready, "item accepted during a query")

endmodule

bind fixed_radius_neighbour_search_unit frns_checker u_frns_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .item_opcode   (item.opcode),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_index  (result.neighbour_index),
    .result_status (result.status),
    .result_count  (result.found_count),
    .result_last   (result.is_last)
);

`default_nettype wire

### verif/fixed_radius_neighbour_search_unit_tb.sv
`timescale 1ns / 1ps

import frns_pkg::*;

typedef struct packed {
    opcode_t                 opcode;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    alive;
    logic [RADIUS_W-1:0]     search_radius;
} search_word_t;

typedef struct packed {
    logic [INDEX_W-1:0] neighbour_index;
    status_t            status;
    logic [COUNT_W-1:0] found_count;
    logic               is_last;
} search_result_t;

class neighbour_tracker;
    logic signed [POS_W-1:0] part_x [DEF_MAX_PARTICLES];
    logic signed [POS_W-1:0] part_y [DEF_MAX_PARTICLES];
    logic signed [POS_W-1:0] part_z [DEF_MAX_PARTICLES];
    bit                      part_live [DEF_MAX_PARTICLES];
    logic [PCOUNT_W-1:0]     scan_count;
    logic [LIMIT_W-1:0]      hit_limit;
    search_result_t          pending_hits [$];
    int                      mismatches;

    function new();
        scan_count = PCOUNT_RESET;
        hit_limit  = LIMIT_RESET;
        mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_PARTICLE_COUNT)
            scan_count = val[PCOUNT_W-1:0];
        else if (idx == CFG_NEIGHBOUR_LIMIT)
            hit_limit = val[LIMIT_W-1:0];
    endfunction

    function void queue_result(search_result_t r);
        pending_hits.insert(pending_hits.size(), r);
    endfunction

    // exact square of a 33-bit difference
    function logic [SQ_W-1:0] axis_sq(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0]        m;
        d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
        m = d[POS_W] ? -d : d;
        return {{(SQ_W-POS_W-1){1'b0}}, m} * {{(SQ_W-POS_W-1){1'b0}}, m};
    endfunction

    function bit in_reach(int i, search_word_t w, logic [RSQ_W-1:0] rsq);
        logic [SUM_W-1:0] total;
        total = {{(SUM_W-SQ_W){1'b0}}, axis_sq(part_x[i], w.pos_x)};
        if (DEF_DIMENSIONS > 1)
            total += {{(SUM_W-SQ_W){1'b0}}, axis_sq(part_y[i], w.pos_y)};
        if (DEF_DIMENSIONS > 2)
            total += {{(SUM_W-SQ_W){1'b0}}, axis_sq(part_z[i], w.pos_z)};
        return total <= {{(SUM_W-RSQ_W){1'b0}}, rsq};
    endfunction

    function void note_word(search_word_t w);
        logic [RSQ_W-1:0] rsq;
        int               span;
        int               found;
        if (w.opcode == OP_LOAD) begin
            if (w.slot < DEF_MAX_PARTICLES) begin
                part_x[w.slot]    = w.pos_x;
                part_y[w.slot]    = w.pos_y;
                part_z[w.slot]    = w.pos_z;
                part_live[w.slot] = w.alive;
            end
            return;
        end
        rsq = {{(RSQ_W-RADIUS_W){1'b0}}, w.search_radius}
            * {{(RSQ_W-RADIUS_W){1'b0}}, w.search_radius};
        span = (scan_count > DEF_MAX_PARTICLES) ? DEF_MAX_PARTICLES : int'(scan_count);
        found = 0;
        for (int i = 0; i < span; i++) begin
            if (!part_live[i] || !in_reach(i, w, rsq))
                continue;
            if (found >= hit_limit) begin
                queue_result(search_result_t'{INDEX_W'(i), ST_OVERFLOW,
                                              COUNT_W'(found), 1'b1});
                return;
            end
            found++;
            queue_result(search_result_t'{INDEX_W'(i), ST_FOUND,
                                          COUNT_W'(found), 1'b0});
        end
        queue_result(search_result_t'{'0, ST_DONE, COUNT_W'(found), 1'b1});
    endfunction

    function void check_result(search_result_t got);
        search_result_t want;
        if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: idx %0d status %0d count %0d last %0d",
                         got.neighbour_index, got.status, got.found_count, got.is_last);
            return;
        end
        want = pending_hits.pop_front();
        if (got.neighbour_index !== want.neighbour_index || got.status !== want.status ||
            got.found_count !== want.found_count || got.is_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected idx %0d status %0d count %0d last %0d",
                         want.neighbour_index, want.status, want.found_count,
                         want.is_last,
                         ", got idx %0d status %0d count %0d last %0d",
                         got.neighbour_index, got.status, got.found_count, got.is_last);
        end
    endfunction
endclass

module fixed_radius_neighbour_search_unit_tb;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int QUIET_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int CHUNKS       = 12;
    localparam int CHUNK_WORDS  = 19;
    localparam int FILL_SLOTS   = 128;

    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [POS_W-1:0] POS_ONE = 32'sh00010000;
    localparam logic [RADIUS_W-1:0]     R_ONE   = 31'h10000;
    localparam logic [RADIUS_W-1:0]     R_MAX   = '1;

    logic   clk = 1'b0;
    logic   rst_n;
    int     send_idle = 29;
    int     recv_idle = 51;
    int     hold_req = 0;
    longint cycle_count = 0;

    int chunk_count [CHUNKS] = '{16, 40, 128, 8, 127, 64, 0, 1, 100, 120, 0, 32};
    int chunk_limit [CHUNKS] = '{63, 5, 63, 0, 63, 10, 3, 1, 63, 20, 0, 2};

    neighbour_tracker tracker = new();

    frns_item_if   item_ch();
    frns_cfg_if    cfg_ch();
    frns_result_if result_ch();

    fixed_radius_neighbour_search_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random back-pressure, plus a long hold when asked
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                tracker.check_result(search_result_t'{result_ch.neighbour_index,
                                                      status_t'(result_ch.status),
                                                      result_ch.found_count,
                                                      result_ch.is_last});
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_word(input search_word_t w);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.opcode        <= w.opcode;
        item_ch.slot          <= w.slot;
        item_ch.pos_x         <= w.pos_x;
        item_ch.pos_y         <= w.pos_y;
        item_ch.pos_z         <= w.pos_z;
        item_ch.alive         <= w.alive;
        item_ch.search_radius <= w.search_radius;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        tracker.note_word(w);
    endtask

    task automatic park_items();
        item_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (tracker.pending_hits.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg valid high so a following write can go back to back
    task automatic write_reg_word(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.write_reg(idx, CFG_DATA_W'(val));
    endtask

    task automatic reconfigure(input int pcount, input int limit);
        park_items();
        drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        write_reg_word(CFG_PARTICLE_COUNT, pcount);
        write_reg_word(CFG_NEIGHBOUR_LIMIT, limit);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic search_word_t make_word(input opcode_t op, input int slot,
                                               input logic signed [POS_W-1:0] x,
                                               input logic signed [POS_W-1:0] y,
                                               input logic signed [POS_W-1:0] z,
                                               input bit live,
                                               input logic [RADIUS_W-1:0] radius);
        return search_word_t'{op, SLOT_W'(slot), x, y, z, live, radius};
    endfunction

    // mostly a tight cluster around the origin (+-4.0), sometimes anywhere
    function automatic logic signed [POS_W-1:0] pick_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endfunction

    function automatic search_word_t pick_word(input bit query, input int span);
        search_word_t w;
        int           reach;
        int           src;
        reach = (span > DEF_MAX_PARTICLES) ? DEF_MAX_PARTICLES : span;
        w.opcode        = query ? OP_QUERY : OP_LOAD;
        w.slot          = SLOT_W'($urandom_range(0, DEF_MAX_PARTICLES - 1));
        w.pos_x         = pick_coord();
        w.pos_y         = pick_coord();
        w.pos_z         = pick_coord();
        w.alive         = ($urandom_range(0, 9) < 7);
        w.search_radius = RADIUS_W'($urandom);
        if (!query)
        begin
            if (reach > 0 && $urandom_range(0, 9) < 7)
                w.slot = SLOT_W'($urandom_range(0, reach - 1));
            return w;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            src = $urandom_range(0, ((reach > 0) ? reach : FILL_SLOTS) - 1);
            w.pos_x = tracker.part_x[src];
            w.pos_y = tracker.part_y[src];
            w.pos_z = tracker.part_z[src];
        end
        case ($urandom_range(0, 9))
            0, 1:             w.search_radius = RADIUS_W'($urandom_range(0, 32'h10000));
            2, 3, 4, 5, 6, 7: w.search_radius = RADIUS_W'($urandom_range(0, 32'h80000));
            8:                ;
            default:          w.search_radius = R_MAX;
        endcase
        return w;
    endfunction

    initial
    begin
        search_word_t w;
        int           pc;
        int           lim;

        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.opcode        <= OP_LOAD;
        item_ch.slot          <= '0;
        item_ch.pos_x         <= '0;
        item_ch.pos_y         <= '0;
        item_ch.pos_z         <= '0;
        item_ch.alive         <= 1'b0;
        item_ch.search_radius <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_PARTICLE_COUNT;
        cfg_ch.data           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the low slots get written once so every scan length used below is legal
        for (int i = 0; i < FILL_SLOTS; i++)
        begin
            w = pick_word(1'b0, 0);
            w.slot = SLOT_W'(i);
            send_word(w);
        end

        reconfigure(4, 63);
        send_word(make_word(OP_LOAD, 0, POS_MIN, POS_MIN, POS_MIN, 1'b1, '0));
        send_word(make_word(OP_LOAD, 1, POS_MAX, POS_MAX, POS_MAX, 1'b1, R_MAX));
        send_word(make_word(OP_LOAD, 2, '0, '0, '0, 1'b0, '0));
        send_word(make_word(OP_LOAD, 3, POS_ONE, '0, '0, 1'b1, '0));
        // slot 3 sits exactly on the radius, then just outside it
        send_word(make_word(OP_QUERY, 1023, '0, '0, '0, 1'b0, R_ONE));
        send_word(make_word(OP_QUERY, 0, '0, '0, '0, 1'b1, R_ONE - 1));
        send_word(make_word(OP_QUERY, 0, POS_MAX, POS_MAX, POS_MAX, 1'b0, R_MAX));
        send_word(make_word(OP_QUERY, 0, POS_MIN, POS_MIN, POS_MIN, 1'b0, '0));
        send_word(make_word(OP_QUERY, 0, POS_MAX, POS_MIN, '0, 1'b0, R_MAX));
        // full-range difference on one axis
        send_word(make_word(OP_LOAD, 2, POS_MAX, '0, '0, 1'b1, '0));
        send_word(make_word(OP_QUERY, 0, POS_MIN, '0, '0, 1'b0, R_MAX));

        reconfigure(4, 0);
        send_word(make_word(OP_QUERY, 0, '0, '0, '0, 1'b0, R_ONE));
        reconfigure(4, 1);
        send_word(make_word(OP_LOAD, 2, '0, POS_ONE / 2, '0, 1'b1, '0));
        send_word(make_word(OP_QUERY, 0, '0, '0, '0, 1'b0, R_ONE));
        reconfigure(0, 63);
        send_word(make_word(OP_QUERY, 0, '0, '0, '0, 1'b0, R_MAX));

        for (int c = 0; c < CHUNKS; c++)
        begin
            case (c / 4)
                0:
                begin
                    send_idle = 29;
                    recv_idle = 51;
                end
                1:
                begin
                    send_idle = 51;
                    recv_idle = 29;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            pc  = chunk_count[c];
            lim = chunk_limit[c];
            if (c == 10)
            begin
                pc  = $urandom_range(1, 64);
                lim = $urandom_range(0, 63);
            end
            reconfigure(pc, lim);
            for (int k = 0; k < CHUNK_WORDS; k++)
            begin
                // long result stall while words keep coming
                if (k == 4 && (c == 1 || c == 9))
                    hold_req++;
                if (k == 15 && (c == 5 || c == 11))
                begin
                    park_items();
                    drain();
                end
                send_word(pick_word($urandom_range(0, 9) < 6, pc));
            end
        end

        park_items();
        drain();
        repeat (QUIET_CYCLES * 5) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### fixed_radius_neighbour_search_unit.f
+incdir+hdl
hdl/frns_pkg.sv
hdl/frns_if.sv
hdl/frns_datapath.sv
hdl/frns_ctrl.sv
hdl/fixed_radius_neighbour_search_unit.sv
hdl/frns_checker.sv
verif/fixed_radius_neighbour_search_unit_tb.sv
